// ===== sv/ciss_pkg.sv =====
`timescale 1ns / 1ps

package ciss_pkg;

   localparam int DATA_W       = 8;
   localparam int CNT_W        = 20;
   localparam int STATE_W      = 2;
   localparam int MASK_W       = 2;
   localparam int NEEDLE_COUNT = 7;
   localparam int NEEDLE_MAX   = 9;
   localparam int HIST_DEPTH   = NEEDLE_MAX - 1;

   typedef logic [DATA_W-1:0] byte_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [MASK_W-1:0] mask_type;
   typedef logic [3:0]        len_type;

   localparam count_type MAX_BYTES = count_type'(524288);
   localparam count_type CNT_MAX   = '1;

   localparam logic [STATE_W-1:0] SCAN_UNAVAIL = 2'd0;
   localparam logic [STATE_W-1:0] SCAN_CLEAR   = 2'd1;
   localparam logic [STATE_W-1:0] SCAN_DETECT  = 2'd2;

   localparam mask_type FAM_INSTR = 2'b01;
   localparam mask_type FAM_HOOK  = 2'b10;

   localparam byte_type UPPER_A = 8'h41;
   localparam byte_type UPPER_Z = 8'h5a;
   localparam byte_type CASE_OFFSET = 8'h20;

   // needle bytes, final byte first
   localparam byte_type NEEDLE_TAIL [NEEDLE_COUNT][NEEDLE_MAX] = '{
      '{8'h61, 8'h64, 8'h69, 8'h72, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h74, 8'h65, 8'h67, 8'h64, 8'h61, 8'h67, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h65, 8'h73, 8'h6f, 8'h70, 8'h78, 8'h00, 8'h00, 8'h00},
      '{8'h64, 8'h65, 8'h73, 8'h6f, 8'h70, 8'h73, 8'h6c, 8'h00, 8'h00},
      '{8'h65, 8'h74, 8'h61, 8'h72, 8'h74, 8'h73, 8'h62, 8'h75, 8'h73},
      '{8'h6b, 8'h73, 8'h69, 8'h67, 8'h79, 8'h7a, 8'h00, 8'h00, 8'h00},
      '{8'h75, 8'h72, 8'h69, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam len_type NEEDLE_LEN [NEEDLE_COUNT] = '{
      4'd5, 4'd6, 4'd6, 4'd7, 4'd9, 4'd6, 4'd4
   };

   localparam mask_type NEEDLE_FAM [NEEDLE_COUNT] = '{
      FAM_INSTR, FAM_INSTR, FAM_HOOK, FAM_HOOK, FAM_HOOK, FAM_HOOK, FAM_HOOK
   };

   typedef struct packed {
      logic     valid;
      byte_type data;
      logic     last;
   } item_type;

   function automatic byte_type fold(byte_type b);
      if (b >= UPPER_A && b <= UPPER_Z) begin
         return byte_type'(b + CASE_OFFSET);
      end
      return b;
   endfunction

   function automatic mask_type match_mask(byte_type cur, byte_type hist [HIST_DEPTH]);
      byte_type win [NEEDLE_MAX];
      mask_type m;
      logic     hit;
      win[0] = cur;
      for (int k = 1; k < NEEDLE_MAX; k++) begin
         win[k] = hist[k-1];
      end
      m = '0;
      for (int i = 0; i < NEEDLE_COUNT; i++) begin
         hit = 1'b1;
         for (int k = 0; k < NEEDLE_MAX; k++) begin
            if (len_type'(k) < NEEDLE_LEN[i] && win[k] != NEEDLE_TAIL[i][k]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            m = m | NEEDLE_FAM[i];
         end
      end
      return m;
   endfunction

endpackage

// ===== sv/ciss_if.sv =====
`timescale 1ns / 1ps

interface ciss_req_if import ciss_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ciss_rsp_if import ciss_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] scan_state;
   mask_type           family_mask;
   modport source (output valid, output scan_state, output family_mask, input ready);
   modport sink (input valid, input scan_state, input family_mask, output ready);
endinterface

interface ciss_csr_if import ciss_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type byte_limit;
   modport source (output valid, output byte_limit, input ready);
   modport sink (input valid, input byte_limit, output ready);
endinterface

// ===== sv/case_insensitive_signature_scanner_top.sv =====
`timescale 1ns / 1ps
// channel    dir  fields                     accepted when
// req_chan   in   data_byte[8], last_byte    valid && ready
// rsp_chan   out  scan_state[2], family_mask  valid && ready
// csr_chan   in   byte_limit[20]              valid && ready (ready always high)
//
// One byte per cycle unless a waiting result holds a last byte; rsp_chan.valid comes from
// the result register, loaded by the match logic as the last byte leaves the input register.
// Reset clears the window, count, mask and limit (limit returns to 524288).
// A waiting result stalls a following last byte and the bytes behind it; others keep flowing.

module case_insensitive_signature_scanner_top import ciss_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ciss_req_if.sink   req_chan,
   ciss_rsp_if.source rsp_chan,
   ciss_csr_if.sink   csr_chan
);

   count_type limit_ff, limit_in;
   item_type  item;
   logic      advance;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_chan.valid) begin
         limit_in = (csr_chan.byte_limit > MAX_BYTES) ? MAX_BYTES : csr_chan.byte_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= MAX_BYTES;
      end else begin
         limit_ff <= limit_in;
      end
   end

   ciss_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .item     (item)
   );

   ciss_match u_match (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .limit    (limit_ff),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sv/ciss_in_reg.sv =====
`timescale 1ns / 1ps

module ciss_in_reg import ciss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ciss_req_if.sink    req_chan,
   input  logic        advance,
   output item_type    item
);

   item_type item_ff;
   item_type item_in;
   logic     take;

   assign req_chan.ready = !item_ff.valid || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign item           = item_ff;

   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.valid = 1'b1;
         item_in.data  = fold(req_chan.data_byte);
         item_in.last  = req_chan.last_byte;
      end else if (advance) begin
         item_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.data <= item_in.data;
      item_ff.last <= item_in.last;
   end

endmodule

// ===== sv/ciss_match.sv =====
`timescale 1ns / 1ps

module ciss_match import ciss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  item_type    item,
   input  count_type   limit,
   output logic        advance,
   ciss_rsp_if.source  rsp_chan
);

   byte_type           hist_ff [HIST_DEPTH];
   byte_type           hist_in [HIST_DEPTH];
   count_type          count_ff, count_in;
   mask_type           mask_ff, mask_in;
   logic               over_ff, over_in;
   logic               out_valid_ff, out_valid_in;
   logic [STATE_W-1:0] out_state_ff, out_state_in;
   mask_type           out_mask_ff, out_mask_in;
   count_type          count_next;
   mask_type           mask_next;
   logic               over_next;

   assign advance = item.valid && (!item.last || !out_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.scan_state  = out_state_ff;
   assign rsp_chan.family_mask = out_mask_ff;

   always_comb begin
      count_next = (count_ff < CNT_MAX) ? count_type'(count_ff + 1'b1) : count_ff;
      over_next  = over_ff || (count_next > limit);
      mask_next  = mask_ff | match_mask(item.data, hist_ff);

      hist_in      = hist_ff;
      count_in     = count_ff;
      mask_in      = mask_ff;
      over_in      = over_ff;
      out_state_in = out_state_ff;
      out_mask_in  = out_mask_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;

      if (advance) begin
         if (item.last) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
               hist_in[k] = '0;
            end
            count_in     = '0;
            mask_in      = '0;
            over_in      = 1'b0;
            out_valid_in = 1'b1;
            if (over_next) begin
               out_state_in = SCAN_UNAVAIL;
               out_mask_in  = '0;
            end else begin
               out_state_in = (mask_next == '0) ? SCAN_CLEAR : SCAN_DETECT;
               out_mask_in  = mask_next;
            end
         end else begin
            hist_in[0] = item.data;
            for (int k = 1; k < HIST_DEPTH; k++) begin
               hist_in[k] = hist_ff[k-1];
            end
            count_in = count_next;
            mask_in  = mask_next;
            over_in  = over_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         count_ff     <= '0;
         mask_ff      <= '0;
         over_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         over_ff      <= over_in;
         out_valid_ff <= out_valid_in;
      end
      out_state_ff <= out_state_in;
      out_mask_ff  <= out_mask_in;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ciss_pkg::*;

   localparam int LATENCY   = 2;
   localparam int KEY_COUNT = 7;
   localparam int RANDOM_BYTES = 1700;
   localparam int PHASE_BYTES  = 200;

   typedef struct packed {
      logic [STATE_W-1:0] verdict;
      mask_type           mask;
   } scan_result_type;

   typedef enum int {KEY_WHOLE, KEY_UPPER, KEY_BROKEN, KEY_CUT} key_form_type;

   // signature bytes, first byte first
   localparam byte_type KEY_TEXT [KEY_COUNT][NEEDLE_MAX] = '{
      '{8'h66, 8'h72, 8'h69, 8'h64, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h67, 8'h61, 8'h64, 8'h67, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00},
      '{8'h78, 8'h70, 8'h6f, 8'h73, 8'h65, 8'h64, 8'h00, 8'h00, 8'h00},
      '{8'h6c, 8'h73, 8'h70, 8'h6f, 8'h73, 8'h65, 8'h64, 8'h00, 8'h00},
      '{8'h73, 8'h75, 8'h62, 8'h73, 8'h74, 8'h72, 8'h61, 8'h74, 8'h65},
      '{8'h7a, 8'h79, 8'h67, 8'h69, 8'h73, 8'h6b, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h69, 8'h72, 8'h75, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam int KEY_LEN [KEY_COUNT] = '{5, 6, 6, 7, 9, 6, 4};
   localparam mask_type KEY_FAM [KEY_COUNT] = '{
      FAM_INSTR, FAM_INSTR, FAM_HOOK, FAM_HOOK, FAM_HOOK, FAM_HOOK, FAM_HOOK
   };

   logic clock = 1'b0;
   logic reset;

   ciss_req_if req_chan ();
   ciss_rsp_if rsp_chan ();
   ciss_csr_if csr_chan ();

   case_insensitive_signature_scanner_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   byte_type        scan_window [HIST_DEPTH];
   count_type       scan_count;
   mask_type        scan_mask;
   logic            scan_over;
   count_type       limit_reg;
   scan_result_type expected_scans [$];
   byte_type        text_buf [$];
   int              fail_count   = 0;
   int              random_bytes = 0;
   logic            sender_quiet = 1'b0;
   logic            sink_quiet   = 1'b0;

   always #2 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void clear_scan();
      for (int k = 0; k < HIST_DEPTH; k++) begin
         scan_window[k] = '0;
      end
      scan_count = '0;
      scan_mask  = '0;
      scan_over  = 1'b0;
   endfunction

   function automatic void scan_byte(byte_type raw, logic lst);
      byte_type        cur;
      count_type       lim;
      logic            hit;
      scan_result_type res;
      cur = (raw >= 8'h41 && raw <= 8'h5a) ? byte_type'(raw + 8'h20) : raw;
      lim = (limit_reg > MAX_BYTES) ? MAX_BYTES : limit_reg;
      if (scan_count != CNT_MAX) begin
         scan_count++;
      end
      if (scan_count > lim) begin
         scan_over = 1'b1;
      end
      for (int i = 0; i < KEY_COUNT; i++) begin
         hit = (cur == KEY_TEXT[i][KEY_LEN[i]-1]);
         for (int k = 1; k < KEY_LEN[i]; k++) begin
            if (scan_window[k-1] != KEY_TEXT[i][KEY_LEN[i]-1-k]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            scan_mask = scan_mask | KEY_FAM[i];
         end
      end
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
         scan_window[k] = scan_window[k-1];
      end
      scan_window[0] = cur;
      if (lst) begin
         if (scan_over) begin
            res.verdict = SCAN_UNAVAIL;
            res.mask    = '0;
         end else begin
            res.verdict = (scan_mask == '0) ? SCAN_CLEAR : SCAN_DETECT;
            res.mask    = scan_mask;
         end
         expected_scans.push_back(res);
         clear_scan();
      end
   endfunction

   task automatic send_byte(byte_type b, logic lst);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= lst;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      scan_byte(b, lst);
   endtask

   task automatic send_text();
      int n;
      for (n = 0; n < text_buf.size(); n++) begin
         send_byte(text_buf[n], n == text_buf.size() - 1);
      end
      text_buf.delete();
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_limit(count_type value);
      wait_drained();
      csr_chan.valid      <= 1'b1;
      csr_chan.byte_limit <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      limit_reg = value;
   endtask

   function automatic void append_key(int idx, key_form_type form);
      int       len;
      int       spot;
      byte_type c;
      len  = (form == KEY_CUT) ? $urandom_range(1, KEY_LEN[idx] - 1) : KEY_LEN[idx];
      spot = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
         c = KEY_TEXT[idx][k];
         if (form == KEY_BROKEN && k == spot) begin
            c = c ^ byte_type'($urandom_range(1, 255));
         end
         if (c >= 8'h61 && c <= 8'h7a && (form == KEY_UPPER || $urandom_range(0, 1) == 1)) begin
            c = c - 8'h20;
         end
         text_buf.push_back(c);
      end
   endfunction

   function automatic void append_filler(int n);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 3))
            0: text_buf.push_back(byte_type'($urandom_range(0, 255)));
            1: text_buf.push_back(8'h0a);
            default: text_buf.push_back(byte_type'($urandom_range(8'h61, 8'h7a)));
         endcase
      end
   endfunction

   task automatic check_scan(logic [STATE_W-1:0] verdict, mask_type mask);
      scan_result_type want;
      if (expected_scans.size() == 0) begin
         report_mismatch($sformatf("result with none pending: state %0d mask %0d",
                                   verdict, mask));
      end else begin
         want = expected_scans.pop_front();
         if (verdict !== want.verdict) begin
            report_mismatch($sformatf("scan_state %0d, want %0d", verdict, want.verdict));
         end
         if (mask !== want.mask) begin
            report_mismatch($sformatf("family_mask %0d, want %0d", mask, want.mask));
         end
      end
   endtask

   task automatic test_directed();
      text_buf.push_back(8'h00);
      send_text();
      text_buf.push_back(8'hff);
      send_text();
      text_buf.push_back(8'h40);
      text_buf.push_back(8'h41);
      text_buf.push_back(8'h5a);
      text_buf.push_back(8'h5b);
      send_text();
      append_key(KEY_COUNT - 1, KEY_UPPER);
      send_text();
      append_key(0, KEY_WHOLE);
      send_text();
      // split a signature across two buffers
      text_buf.push_back(KEY_TEXT[KEY_COUNT-1][0]);
      text_buf.push_back(KEY_TEXT[KEY_COUNT-1][1]);
      send_text();
      text_buf.push_back(KEY_TEXT[KEY_COUNT-1][2]);
      text_buf.push_back(KEY_TEXT[KEY_COUNT-1][3]);
      send_text();
      wait_drained();
   endtask

   task automatic test_limits();
      write_limit('0);
      append_key(KEY_COUNT - 1, KEY_WHOLE);
      send_text();
      write_limit(count_type'(1));
      text_buf.push_back(8'h61);
      send_text();
      text_buf.push_back(8'h61);
      text_buf.push_back(8'h62);
      send_text();
      write_limit(count_type'(5));
      append_key(0, KEY_WHOLE);
      send_text();
      text_buf.push_back(8'h20);
      append_key(0, KEY_WHOLE);
      send_text();
      // limit above MAX_BYTES is held at MAX_BYTES
      write_limit(CNT_MAX);
      append_key(4, KEY_WHOLE);
      send_text();
      write_limit(MAX_BYTES);
   endtask

   task automatic test_random();
      int           phase_bytes;
      count_type    lim;
      key_form_type form;
      while (random_bytes < RANDOM_BYTES) begin
         case ($urandom_range(0, 7))
            0, 1: lim = count_type'($urandom_range(1, 12));
            2, 3: lim = count_type'($urandom_range(13, 60));
            4: lim = MAX_BYTES;
            5: lim = CNT_MAX;
            6: lim = '0;
            default: lim = count_type'($urandom);
         endcase
         write_limit(lim);
         sender_quiet = ($urandom_range(0, 3) == 0);
         sink_quiet   = ($urandom_range(0, 3) == 0);
         phase_bytes  = 0;
         while (phase_bytes < PHASE_BYTES && random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
               append_filler($urandom_range(1, 30));
            end else begin
               for (int s = $urandom_range(1, 3); s > 0; s--) begin
                  append_filler($urandom_range(0, 6));
                  case ($urandom_range(0, 4))
                     0: form = KEY_BROKEN;
                     1: form = KEY_CUT;
                     default: form = KEY_WHOLE;
                  endcase
                  append_key($urandom_range(0, KEY_COUNT - 1), form);
               end
               append_filler($urandom_range(0, 4));
            end
            phase_bytes  += text_buf.size();
            random_bytes += text_buf.size();
            send_text();
            if ($urandom_range(0, 15) == 0) begin
               wait_drained();
            end
         end
      end
      sender_quiet = 1'b0;
      sink_quiet   = 1'b0;
   endtask

   initial begin : result_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = sink_quiet ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         check_scan(rsp_chan.scan_state, rsp_chan.family_mask);
      end
   end

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= '0;
      req_chan.last_byte  <= 1'b0;
      csr_chan.valid      <= 1'b0;
      csr_chan.byte_limit <= '0;
      limit_reg = MAX_BYTES;
      clear_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      test_random();
      wait_drained();
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
